[design/pidaw_pkg.sv]
package pidaw_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned IntWidth = 48;
  localparam int unsigned FracBits = 16;
  localparam int unsigned PeriodBits = 24;
  localparam int unsigned InvpBits = 32;
  localparam int unsigned AccWidth = 128;

  // Register byte addresses divided by four.
  localparam logic [2:0] RegCenter = 3'd0;
  localparam logic [2:0] RegUpper = 3'd1;
  localparam logic [2:0] RegLower = 3'd2;
  localparam logic [2:0] RegGainP = 3'd3;
  localparam logic [2:0] RegGainI = 3'd4;
  localparam logic [2:0] RegGainD = 3'd5;
  localparam logic [2:0] RegPeriod = 3'd6;
  localparam logic [2:0] RegInvp = 3'd7;

  typedef struct packed {
    logic enable;
    logic signed [DataWidth-1:0] setpoint;
    logic signed [DataWidth-1:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] command;
    logic hit_upper;
    logic hit_lower;
    logic windup_cleared;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D1,
    ST_MUL_D2,
    ST_MUL_S,
    ST_SUM,
    ST_CLAMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0] shift;
  } mul_req_t;

endpackage

[design/pidaw_mul.sv]
// Shift-add multiplier: one multiplier bit per cycle, magnitude form,
// then a floor shift and saturation to 64 bits.
module pidaw_mul (
  input  logic clk,
  input  logic rst,
  input  pidaw_pkg::mul_req_t req,
  output logic done,
  output logic signed [63:0] result
);

  logic busy;
  logic [6:0] count;
  logic [63:0] mcand;
  logic [63:0] mplier;
  logic [127:0] acc;
  logic neg;
  logic [5:0] shift;
  logic [63:0] mag_a;
  logic [63:0] mag_b;
  logic [64:0] step_sum;
  logic [127:0] sacc;
  logic [127:0] shifted;

  assign mag_a = req.a[63] ? 64'(-req.a) : req.a;
  assign mag_b = req.b[63] ? 64'(-req.b) : req.b;
  assign step_sum = {1'b0, acc[127:64]} + (mplier[0] ? {1'b0, mcand} : 65'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= '0;
        mcand <= mag_a;
        mplier <= mag_b;
        acc <= '0;
        neg <= req.a[63] ^ req.b[63];
        shift <= req.shift;
      end else if (busy) begin
        // Add the multiplicand into the high half, then shift right one bit.
        acc <= {step_sum, acc[63:1]};
        mplier <= mplier >> 1;
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sacc = neg ? 128'(-acc) : acc;
  assign shifted = 128'($signed(sacc) >>> shift);

  always_comb begin
    if (shifted[127:63] == '0 || shifted[127:63] == '1) begin
      result = shifted[63:0];
    end else if (shifted[127]) begin
      result = {1'b1, 63'd0};
    end else begin
      result = {1'b0, {63{1'b1}}};
    end
  end

endmodule

[design/pidaw_regs.sv]
module pidaw_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output logic signed [31:0] center,
  output logic signed [31:0] upper_limit,
  output logic signed [31:0] lower_limit,
  output logic signed [31:0] gain_p,
  output logic signed [31:0] gain_i,
  output logic signed [31:0] gain_d,
  output logic [23:0] sample_period,
  output logic [31:0] inverse_period
);

  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      upper_limit <= 32'sh7fffffff;
      lower_limit <= 32'sh80000000;
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      sample_period <= 24'd167772;
      inverse_period <= 32'd6553600;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        pidaw_pkg::RegCenter: center <= pwdata;
        pidaw_pkg::RegUpper: upper_limit <= pwdata;
        pidaw_pkg::RegLower: lower_limit <= pwdata;
        pidaw_pkg::RegGainP: gain_p <= pwdata;
        pidaw_pkg::RegGainI: gain_i <= pwdata;
        pidaw_pkg::RegGainD: gain_d <= pwdata;
        pidaw_pkg::RegPeriod: sample_period <= pwdata[23:0];
        pidaw_pkg::RegInvp: inverse_period <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pidaw_pkg::RegCenter: prdata = center;
      pidaw_pkg::RegUpper: prdata = upper_limit;
      pidaw_pkg::RegLower: prdata = lower_limit;
      pidaw_pkg::RegGainP: prdata = gain_p;
      pidaw_pkg::RegGainI: prdata = gain_i;
      pidaw_pkg::RegGainD: prdata = gain_d;
      pidaw_pkg::RegPeriod: prdata = {8'd0, sample_period};
      pidaw_pkg::RegInvp: prdata = inverse_period;
      default: prdata = '0;
    endcase
  end

endmodule

[design/pid_controller_antiwindup_unit.sv]
// PID controller with anti-windup and output clamp, signed Q16.16. One sample
// is worked at a time; the work on a sample is five 64-step passes of the
// single bit-serial shift-add multiplier (P, I, two for D, integral step),
// followed by sums and clamping. The result register holds the beat until
// taken; the next sample is accepted once the result is loaded into it.
module pid_controller_antiwindup_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  pidaw_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output pidaw_pkg::out_item_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam logic signed [63:0] SMax = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SMin = {1'b1, 63'd0};

  logic signed [31:0] center, upper_limit, lower_limit, gain_p, gain_i, gain_d;
  logic [23:0] sample_period;
  logic [31:0] inverse_period;

  pidaw_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .center, .upper_limit, .lower_limit, .gain_p, .gain_i, .gain_d,
    .sample_period, .inverse_period
  );

  pidaw_pkg::state_t state, state_next;
  pidaw_pkg::mul_req_t req;
  logic mul_done;
  logic signed [63:0] mul_res;

  pidaw_mul u_mul (.clk, .rst, .req, .done(mul_done), .result(mul_res));

  logic enable;
  logic signed [31:0] err, prev_err;
  logic signed [47:0] integ;
  logic signed [63:0] p_term, i_term, d_term, sum;
  logic cleared, hit_up, hit_lo;
  logic signed [32:0] diff;
  logic signed [32:0] bound;
  logic [47:0] integ_mag;
  logic signed [63:0] s1, s2, cmd_raw, cmd_up;
  logic signed [64:0] integ_new;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMax)) return SMax;
    if (s < 65'(SMin)) return SMin;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SMax)) return SMax;
    if (s < 65'(SMin)) return SMin;
    return s[63:0];
  endfunction

  assign diff = 33'(in_data.setpoint) - 33'(in_data.measurement);
  assign bound = 33'(upper_limit) - 33'(center);
  assign integ_mag = integ[47] ? 48'(-integ) : integ;
  assign s1 = sat_add(p_term, i_term);
  assign s2 = sat_add(s1, d_term);
  assign cmd_raw = sat_sub(64'(center), sum);
  assign integ_new = 65'(integ) + 65'(mul_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidaw_pkg::ST_IDLE;
      out_valid <= 1'b0;
      integ <= '0;
      prev_err <= '0;
    end else begin
      state <= state_next;
      out_valid <= (state == pidaw_pkg::ST_OUT) || (out_valid && out_stall);
      unique case (state)
        pidaw_pkg::ST_IDLE: begin
          if (in_valid) begin
            enable <= in_data.enable;
            if (diff > 33'sh07fffffff) begin
              err <= 32'sh7fffffff;
            end else if (diff < -33'sh080000000) begin
              err <= 32'sh80000000;
            end else begin
              err <= diff[31:0];
            end
          end
        end
        pidaw_pkg::ST_PREP: begin
          // Anti-windup: drop the integral if its magnitude passed the bound or the bound is negative.
          cleared <= 1'b0;
          if (bound < 0 || 49'(integ_mag) > 49'(bound)) begin
            integ <= '0;
            cleared <= 1'b1;
          end
        end
        pidaw_pkg::ST_MUL_P: if (mul_done) p_term <= mul_res;
        pidaw_pkg::ST_MUL_I: if (mul_done) i_term <= mul_res;
        pidaw_pkg::ST_MUL_D1: if (mul_done) d_term <= mul_res;
        pidaw_pkg::ST_MUL_D2: if (mul_done) d_term <= mul_res;
        pidaw_pkg::ST_MUL_S: begin
          if (mul_done) begin
            prev_err <= err;
            if (!enable) begin
              integ <= '0;
            end else if (integ_new > 65'sh07fffffffffff) begin
              integ <= 48'sh7fffffffffff;
            end else if (integ_new < -65'sh0800000000000) begin
              integ <= 48'sh800000000000;
            end else begin
              integ <= integ_new[47:0];
            end
          end
        end
        pidaw_pkg::ST_SUM: sum <= s2;
        pidaw_pkg::ST_CLAMP: begin
          hit_up <= cmd_raw > 64'(upper_limit);
          hit_lo <= 1'b0;
          cmd_up <= (cmd_raw > 64'(upper_limit)) ? 64'(upper_limit) : cmd_raw;
        end
        pidaw_pkg::ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.hit_upper <= hit_up;
            out_data.windup_cleared <= cleared;
            if (cmd_up < 64'(lower_limit)) begin
              out_data.command <= lower_limit;
              out_data.hit_lower <= 1'b1;
            end else begin
              out_data.command <= cmd_up[31:0];
              out_data.hit_lower <= hit_lo;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    req = '0;
    in_stall = (state != pidaw_pkg::ST_IDLE);
    unique case (state)
      pidaw_pkg::ST_IDLE: if (in_valid) state_next = pidaw_pkg::ST_PREP;
      pidaw_pkg::ST_PREP: begin
        state_next = pidaw_pkg::ST_MUL_P;
        req = '{start: 1'b1, a: 64'(gain_p), b: 64'(err), shift: 6'(pidaw_pkg::FracBits)};
      end
      pidaw_pkg::ST_MUL_P: if (mul_done) begin
        state_next = pidaw_pkg::ST_MUL_I;
        req = '{start: 1'b1, a: 64'(gain_i), b: 64'(integ), shift: 6'(pidaw_pkg::FracBits)};
      end
      pidaw_pkg::ST_MUL_I: if (mul_done) begin
        state_next = pidaw_pkg::ST_MUL_D1;
        req = '{start: 1'b1, a: 64'(gain_d), b: 64'(err) - 64'(prev_err),
                shift: 6'(pidaw_pkg::FracBits)};
      end
      pidaw_pkg::ST_MUL_D1: if (mul_done) begin
        state_next = pidaw_pkg::ST_MUL_D2;
        req = '{start: 1'b1, a: mul_res, b: {32'd0, inverse_period},
                shift: 6'(pidaw_pkg::FracBits)};
      end
      pidaw_pkg::ST_MUL_D2: if (mul_done) begin
        state_next = pidaw_pkg::ST_MUL_S;
        req = '{start: 1'b1, a: 64'(err), b: {40'd0, sample_period},
                shift: 6'(pidaw_pkg::PeriodBits)};
      end
      pidaw_pkg::ST_MUL_S: if (mul_done) state_next = pidaw_pkg::ST_SUM;
      pidaw_pkg::ST_SUM: state_next = pidaw_pkg::ST_CLAMP;
      pidaw_pkg::ST_CLAMP: state_next = pidaw_pkg::ST_OUT;
      pidaw_pkg::ST_OUT: if (!out_valid || !out_stall) state_next = pidaw_pkg::ST_IDLE;
      default: state_next = pidaw_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != pidaw_pkg::ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_clamp_up: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !out_data.hit_lower |->
    $signed(out_data.command) <= upper_limit) else $error("clamp fault");
`endif

endmodule
